FILE: sv/bcd_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the block cache directory: field widths, operation codes
// and the control and status bundles between the sequencer and the scan unit.
// No dependencies.
package bcd_pkg;

	localparam int DEF_ENTRIES = 16;

	localparam int OPCODE_W = 2;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 32;
	localparam int TIME_W   = 32;
	localparam int SLOT_W   = 4;
	localparam int CFG_W    = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_INSTALL = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_RSVD    = 2'd3;

	typedef struct packed {
		logic start;
		logic step;
		logic first;
		logic entry_valid;
	} scan_ctrl_t;

	typedef struct packed {
		logic found;
		logic dev_match;
	} scan_stat_t;

endpackage

FILE: sv/bcd_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the block cache directory.
// Depends on bcd_pkg for the field widths.
interface bcd_req_if import bcd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [DEV_W-1:0]    device_id;
	logic [BLK_W-1:0]    block_number;
	logic [TIME_W-1:0]   now;
	logic [SLOT_W-1:0]   install_slot;

	modport source (output valid, opcode, device_id, block_number, now, install_slot,
		input ready);
	modport sink (input valid, opcode, device_id, block_number, now, install_slot,
		output ready);
endinterface

interface bcd_rsp_if import bcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, hit, slot, input ready);
	modport sink (input valid, hit, slot, output ready);
endinterface

FILE: sv/bcd_tag_ram.sv
`timescale 1ns / 1ps
// Tag and time stamp storage of the directory: one write port, one registered read port.
// Depends on bcd_pkg for the field widths.
module bcd_tag_ram import bcd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES,
	parameter int IDX_W   = 4
) (
	input  logic              clk,
	input  logic              we_tag,
	input  logic              we_stamp,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DEV_W-1:0]  wdev,
	input  logic [BLK_W-1:0]  wblk,
	input  logic [TIME_W-1:0] wstamp,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DEV_W-1:0]  rdev_s1,
	output logic [BLK_W-1:0]  rblk_s1,
	output logic [TIME_W-1:0] rstamp_s1
);

	logic [DEV_W-1:0]  dev_mem   [ENTRIES];
	logic [BLK_W-1:0]  blk_mem   [ENTRIES];
	logic [TIME_W-1:0] stamp_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we_tag) begin
			dev_mem[waddr] <= wdev;
			blk_mem[waddr] <= wblk;
		end
		if (we_stamp) begin
			stamp_mem[waddr] <= wstamp;
		end
	end

	always_ff @(posedge clk) begin
		rdev_s1   <= dev_mem[raddr];
		rblk_s1   <= blk_mem[raddr];
		rstamp_s1 <= stamp_mem[raddr];
	end

endmodule

FILE: sv/bcd_scan.sv
`timescale 1ns / 1ps
// Scan unit: tag compare and age compare applied to one directory entry per step,
// keeping the first hit and the running replacement victim. Depends on bcd_pkg.
module bcd_scan import bcd_pkg::*; #(
	parameter int IDX_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DEV_W-1:0]  entry_dev,
	input  logic [BLK_W-1:0]  entry_blk,
	input  logic [TIME_W-1:0] entry_stamp,
	input  logic [DEV_W-1:0]  key_dev,
	input  logic [BLK_W-1:0]  key_blk,
	input  logic [TIME_W-1:0] now,
	output scan_stat_t        stat,
	output logic [IDX_W-1:0]  hit_idx,
	output logic [IDX_W-1:0]  victim_idx
);

	logic              found_q;
	logic              empty_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [IDX_W-1:0]  victim_q;
	logic [TIME_W-1:0] best_age_q;

	logic              dev_eq;
	logic              match;
	logic [TIME_W-1:0] age;
	logic              older;

	assign dev_eq = (entry_dev == key_dev);
	assign match  = ctrl.entry_valid && dev_eq && (entry_blk == key_blk);
	// Age wraps modulo the stamp width, so a stamp from before a counter wrap still ages.
	assign age    = now - entry_stamp;
	assign older  = age > best_age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (ctrl.start) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (ctrl.step) begin
			if (match) begin
				found_q <= 1'b1;
			end
			if (!ctrl.entry_valid) begin
				empty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (match && !found_q) begin
				hit_idx_q <= idx;
			end
			// The first empty entry wins outright; until one is seen, keep the oldest.
			if (!empty_q) begin
				if (!ctrl.entry_valid) begin
					victim_q <= idx;
				end else if (ctrl.first || older) begin
					victim_q   <= idx;
					best_age_q <= age;
				end
			end
		end
	end

	assign stat.found     = found_q;
	assign stat.dev_match = ctrl.entry_valid && dev_eq;
	assign hit_idx        = hit_idx_q;
	assign victim_idx     = victim_q;

endmodule

FILE: sv/block_cache_directory_oldest_replace_core.sv
`timescale 1ns / 1ps
// Fully associative block cache directory with oldest-entry replacement.
// Lookup and clear scan one entry per cycle through the tag RAM read port and the shared
// compare unit, over the n active entries, then pass through DRAIN and FINISH before the
// registered response; the next request is taken only once the core is back in IDLE.
// Install and the unused opcode go straight to FINISH and respond from there;
// an unaccepted response holds the next one back. arst_n clears valid bits, count to 16.
module block_cache_directory_oldest_replace_core import bcd_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	bcd_req_if.sink          req,
	bcd_rsp_if.source        rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]          state_q;
	logic [CFG_W-1:0]    cfg_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [OPCODE_W-1:0] op_q;
	logic [DEV_W-1:0]    dev_q;
	logic [BLK_W-1:0]    blk_q;
	logic [TIME_W-1:0]   now_q;
	logic [CNT_W-1:0]    n_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [SLOT_W-1:0]   res_slot_q;

	logic                step_s1;
	logic                first_s1;
	logic                ev_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic                out_valid_q;
	logic                out_hit_q;
	logic [SLOT_W-1:0]   out_slot_q;

	logic [CNT_W-1:0]    n_cur;
	logic                accept;
	logic                last;
	logic                islot_ok;
	logic [31:0]         islot_ext;
	logic [IDX_W-1:0]    islot_idx;
	logic                install_wr;
	logic                finish_go;
	logic                stamp_wr;
	logic                clear_hit;

	logic [IDX_W-1:0]    ram_waddr;
	logic [TIME_W-1:0]   ram_wstamp;
	logic [DEV_W-1:0]    rdev_s1;
	logic [BLK_W-1:0]    rblk_s1;
	logic [TIME_W-1:0]   rstamp_s1;

	scan_ctrl_t          sc_ctrl;
	scan_stat_t          sc_stat;
	logic [IDX_W-1:0]    hit_idx;
	logic [IDX_W-1:0]    victim_idx;
	logic [IDX_W-1:0]    lookup_idx;
	logic [31:0]         lookup_ext;

	// Active entry count: zero acts as one, anything above the directory size as the size.
	always_comb begin
		if (cfg_q == '0) begin
			n_cur = CNT_W'(1);
		end else if (32'(cfg_q) > ENTRIES) begin
			n_cur = CNT_W'(ENTRIES);
		end else begin
			n_cur = CNT_W'(cfg_q);
		end
	end

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == ST_IDLE);
	assign last       = ((IDX_W+1)'(ptr_q) + (IDX_W+1)'(1)) == (IDX_W+1)'(n_q);
	assign islot_ext  = 32'(req.install_slot);
	assign islot_ok   = islot_ext < ENTRIES;
	assign islot_idx  = islot_ext[IDX_W-1:0];
	assign install_wr = accept && (req.opcode == OP_INSTALL) && islot_ok;
	assign finish_go  = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);
	assign stamp_wr   = (state_q == ST_FINISH) && (op_q == OP_LOOKUP) && sc_stat.found;
	assign clear_hit  = step_s1 && (op_q == OP_CLEAR) && sc_stat.dev_match;

	assign ram_waddr  = (state_q == ST_FINISH) ? hit_idx : islot_idx;
	assign ram_wstamp = (state_q == ST_FINISH) ? now_q : req.now;

	assign lookup_idx = sc_stat.found ? hit_idx : victim_idx;
	assign lookup_ext = 32'(lookup_idx);

	assign sc_ctrl.start       = accept;
	assign sc_ctrl.step        = step_s1;
	assign sc_ctrl.first       = first_s1;
	assign sc_ctrl.entry_valid = ev_s1;

	bcd_tag_ram #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_ram (
		.clk       (clk),
		.we_tag    (install_wr),
		.we_stamp  (install_wr || stamp_wr),
		.waddr     (ram_waddr),
		.wdev      (req.device_id),
		.wblk      (req.block_number),
		.wstamp    (ram_wstamp),
		.raddr     (ptr_q),
		.rdev_s1   (rdev_s1),
		.rblk_s1   (rblk_s1),
		.rstamp_s1 (rstamp_s1)
	);

	bcd_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (sc_ctrl),
		.idx         (idx_s1),
		.entry_dev   (rdev_s1),
		.entry_blk   (rblk_s1),
		.entry_stamp (rstamp_s1),
		.key_dev     (dev_q),
		.key_blk     (blk_q),
		.now         (now_q),
		.stat        (sc_stat),
		.hit_idx     (hit_idx),
		.victim_idx  (victim_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (clear_hit) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (install_wr) begin
				valid_q[islot_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			step_s1  <= 1'b0;
		end else begin
			step_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						if (req.opcode == OP_LOOKUP || req.opcode == OP_CLEAR) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			dev_q <= req.device_id;
			blk_q <= req.block_number;
			now_q <= req.now;
			n_q   <= n_cur;
			if (req.opcode == OP_INSTALL) begin
				res_slot_q <= req.install_slot;
			end else begin
				res_slot_q <= '0;
			end
		end
		idx_s1   <= ptr_q;
		first_s1 <= (ptr_q == '0);
		ev_s1    <= valid_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			if (op_q == OP_LOOKUP) begin
				out_hit_q  <= sc_stat.found;
				out_slot_q <= lookup_ext[SLOT_W-1:0];
			end else begin
				out_hit_q  <= 1'b0;
				out_slot_q <= res_slot_q;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit   = out_hit_q;
	assign rsp.slot  = out_slot_q;

endmodule

FILE: sv/bcd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the block cache directory, bound to the top level.
// Depends on bcd_pkg for the slot width.
module bcd_checker import bcd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_hit,
	input logic [SLOT_W-1:0] rsp_slot
);

	// A waiting response keeps its contents until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_slot))
		else $error("response changed while stalled");

	// Only one transaction is in the directory at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a transaction is in progress");

	// A new response always comes out of a busy period, never straight from idle.
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response raised without a transaction in progress");

endmodule

bind block_cache_directory_oldest_replace_core bcd_checker u_bcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_hit   (rsp.hit),
	.rsp_slot  (rsp.slot)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the block cache directory core: random and directed
// lookups, installs and clears checked against an in-bench directory predictor.
// Depends on bcd_pkg, the bcd_req_if / bcd_rsp_if interfaces and the core RTL.
module tb_top;
	import bcd_pkg::*;

	localparam int ENTRIES      = DEF_ENTRIES;
	localparam int SETTLE       = ENTRIES + 6;
	localparam int PHASE_ITEMS  = 190;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [DEV_W-1:0]    device_id;
		logic [BLK_W-1:0]    block_number;
		logic [TIME_W-1:0]   now;
		logic [SLOT_W-1:0]   install_slot;
	} dir_req_t;

	typedef struct {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} dir_rsp_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	bcd_req_if req_if ();
	bcd_rsp_if rsp_if ();

	block_cache_directory_oldest_replace_core #(.ENTRIES(ENTRIES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if.sink),
		.rsp       (rsp_if.source)
	);

	// Predicted directory contents and entry count.
	logic              dir_valid [ENTRIES] = '{default: 1'b0};
	logic [DEV_W-1:0]  dir_dev   [ENTRIES] = '{default: '0};
	logic [BLK_W-1:0]  dir_blk   [ENTRIES] = '{default: '0};
	logic [TIME_W-1:0] dir_stamp [ENTRIES] = '{default: '0};
	logic [CFG_W-1:0]  dir_cfg = CFG_RESET;

	dir_req_t    req_pending [$];
	dir_rsp_t    expected_rsp [$];
	dir_req_t    next_req;
	dir_rsp_t    rsp_want;
	logic        req_taken = 1'b0;
	int unsigned req_gap = 0;
	int unsigned rsp_stall = 0;
	int unsigned req_gap_pct = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned error_count = 0;
	logic [TIME_W-1:0] tick = '0;

	always #5 clk = ~clk;

	function automatic int unsigned active_entries(input logic [CFG_W-1:0] cfg);
		if (cfg > ENTRIES)
			return ENTRIES;
		if (cfg == 0)
			return 1;
		return 32'(cfg);
	endfunction

	// Applies one request to the predicted directory and returns its response.
	function automatic dir_rsp_t dir_access(input dir_req_t r);
		dir_rsp_t          res;
		int unsigned       span;
		int unsigned       best;
		logic [TIME_W-1:0] age;
		logic [TIME_W-1:0] best_age;
		logic              found;
		res.hit  = 1'b0;
		res.slot = '0;
		span     = active_entries(dir_cfg);
		found    = 1'b0;
		case (r.opcode)
			OP_LOOKUP: begin
				for (int i = 0; i < span && !found; i++) begin
					if (dir_valid[i] && dir_dev[i] == r.device_id &&
							dir_blk[i] == r.block_number) begin
						dir_stamp[i] = r.now;
						res.hit      = 1'b1;
						res.slot     = SLOT_W'(i);
						found        = 1'b1;
					end
				end
				if (!found) begin
					// Victim: first empty entry, else the oldest, lowest index on ties.
					best     = 0;
					best_age = '0;
					for (int i = 0; i < span && !found; i++) begin
						age = r.now - dir_stamp[i];
						if (!dir_valid[i]) begin
							best  = i;
							found = 1'b1;
						end else if (i == 0 || age > best_age) begin
							best     = i;
							best_age = age;
						end
					end
					res.slot = SLOT_W'(best);
				end
			end
			OP_INSTALL: begin
				if (r.install_slot < ENTRIES) begin
					dir_valid[r.install_slot] = 1'b1;
					dir_dev[r.install_slot]   = r.device_id;
					dir_blk[r.install_slot]   = r.block_number;
					dir_stamp[r.install_slot] = r.now;
				end
				res.slot = r.install_slot;
			end
			OP_CLEAR: begin
				for (int i = 0; i < span; i++)
					if (dir_valid[i] && dir_dev[i] == r.device_id)
						dir_valid[i] = 1'b0;
			end
			default: ;
		endcase
		return res;
	endfunction

	// Draws a request from a small tag pool so that hits and duplicates are common.
	function automatic dir_req_t random_request(input int unsigned span);
		logic [DEV_W-1:0] dev_pool [5] = '{8'h00, 8'h01, 8'h02, 8'h80, 8'hFF};
		logic [BLK_W-1:0] blk_pool [8] = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFE};
		dir_req_t    r;
		int unsigned pick;
		if ($urandom_range(0, 49) == 0)
			tick = $urandom();
		else
			tick = tick + $urandom_range(0, 64);
		if ($urandom_range(0, 9) == 0) begin
			r.opcode       = OPCODE_W'($urandom_range(0, 3));
			r.device_id    = DEV_W'($urandom());
			r.block_number = $urandom();
			r.now          = $urandom();
			r.install_slot = SLOT_W'($urandom());
			return r;
		end
		pick = $urandom_range(0, 99);
		if (pick < 50)
			r.opcode = OP_LOOKUP;
		else if (pick < 90)
			r.opcode = OP_INSTALL;
		else if (pick < 97)
			r.opcode = OP_CLEAR;
		else
			r.opcode = OP_RSVD;
		r.device_id    = dev_pool[$urandom_range(0, 4)];
		r.block_number = blk_pool[$urandom_range(0, 7)];
		r.now          = tick;
		if ($urandom_range(0, 4) == 0)
			r.install_slot = SLOT_W'($urandom_range(0, ENTRIES - 1));
		else
			r.install_slot = SLOT_W'($urandom_range(0, span - 1));
		return r;
	endfunction

	task automatic push_req(input logic [OPCODE_W-1:0] op, input logic [DEV_W-1:0] dev,
			input logic [BLK_W-1:0] blk, input logic [TIME_W-1:0] at,
			input logic [SLOT_W-1:0] islot);
		dir_req_t r;
		r.opcode       = op;
		r.device_id    = dev;
		r.block_number = blk;
		r.now          = at;
		r.install_slot = islot;
		req_pending.push_back(r);
	endtask

	// Waits until no transaction is queued, in flight or awaiting its response.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (!(req_pending.size() == 0 && !req_if.valid && expected_rsp.size() == 0));
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_entry_count(input logic [CFG_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		dir_cfg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic flag_error(input string msg);
		$display("tb_top: mismatch at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// Request driver: a transaction is held until accepted, then optionally a gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_taken) begin
			if (req_gap > 0) begin
				req_if.valid <= 1'b0;
				req_gap--;
			end else if (req_pending.size() > 0) begin
				next_req = req_pending.pop_front();
				req_if.valid        <= 1'b1;
				req_if.opcode       <= next_req.opcode;
				req_if.device_id    <= next_req.device_id;
				req_if.block_number <= next_req.block_number;
				req_if.now          <= next_req.now;
				req_if.install_slot <= next_req.install_slot;
				if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct)
					req_gap = $urandom_range(1, 15);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Response back-pressure in random bursts.
	always @(negedge clk) begin
		if (rsp_stall == 0 && rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct)
			rsp_stall = $urandom_range(1, 15);
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (rsp_stall > 0) begin
			rsp_if.ready <= 1'b0;
			rsp_stall--;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// Monitor: predicts on each accepted request, checks each accepted response.
	always @(posedge clk) begin
		req_taken = arst_n && req_if.valid === 1'b1 && req_if.ready === 1'b1;
		if (req_taken)
			expected_rsp.push_back(dir_access('{req_if.opcode, req_if.device_id,
				req_if.block_number, req_if.now, req_if.install_slot}));
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (expected_rsp.size() == 0) begin
				flag_error("response transaction with no request outstanding");
			end else begin
				rsp_want = expected_rsp.pop_front();
				if (rsp_if.hit !== rsp_want.hit)
					flag_error($sformatf("hit %b, expected %b", rsp_if.hit, rsp_want.hit));
				if (rsp_if.slot !== rsp_want.slot)
					flag_error($sformatf("slot %0d, expected %0d", rsp_if.slot,
						rsp_want.slot));
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_W-1:0] cfg_plan [10] = '{5'd16, 5'd1, 5'd4, 5'd17, 5'd8, 5'd0, 5'd31,
			5'd2, 5'd12, 5'd16};
		dir_req_t    r;
		int unsigned span;
		int unsigned count;
		logic        held;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		held                = 1'b0;
		req_if.valid        = 1'b0;
		req_if.opcode       = OP_LOOKUP;
		req_if.device_id    = '0;
		req_if.block_number = '0;
		req_if.now          = '0;
		req_if.install_slot = '0;
		rsp_if.ready        = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty victim, hit, all-ones tag, duplicate tag, clear, unused opcode.
		req_gap_pct   = 20;
		rsp_stall_pct = 20;
		push_req(OP_LOOKUP,  8'h00, 32'h0,         32'd0,         4'd0);
		push_req(OP_INSTALL, 8'h00, 32'h0,         32'd10,        4'd0);
		push_req(OP_LOOKUP,  8'h00, 32'h0,         32'd20,        4'd0);
		push_req(OP_INSTALL, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		push_req(OP_LOOKUP,  8'hFF, 32'hFFFF_FFFF, 32'd30,        4'd0);
		push_req(OP_INSTALL, 8'h00, 32'h0,         32'd40,        4'd3);
		push_req(OP_LOOKUP,  8'h00, 32'h0,         32'd50,        4'd0);
		push_req(OP_CLEAR,   8'h00, 32'h0,         32'd60,        4'd0);
		push_req(OP_LOOKUP,  8'h00, 32'h0,         32'd70,        4'd0);
		push_req(OP_RSVD,    8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);

		// Two entries: oldest victim, equal-age tie, install past the searched range.
		write_entry_count(5'd2);
		push_req(OP_INSTALL, 8'h01, 32'd7,  32'd100, 4'd0);
		push_req(OP_INSTALL, 8'h01, 32'd8,  32'd50,  4'd1);
		push_req(OP_LOOKUP,  8'h01, 32'd9,  32'd200, 4'd0);
		push_req(OP_INSTALL, 8'h01, 32'd8,  32'd100, 4'd1);
		push_req(OP_LOOKUP,  8'h01, 32'd9,  32'd300, 4'd0);
		push_req(OP_INSTALL, 8'h02, 32'd5,  32'd0,   4'd5);
		push_req(OP_LOOKUP,  8'h02, 32'd5,  32'd310, 4'd0);

		// Zero acts as one entry, and counts above the directory size act as all of it.
		write_entry_count(5'd0);
		push_req(OP_LOOKUP,  8'h02, 32'd5,  32'd320, 4'd0);
		write_entry_count(5'd31);
		push_req(OP_LOOKUP,  8'h02, 32'd5,  32'd330, 4'd0);
		push_req(OP_CLEAR,   8'h01, 32'd0,  32'd340, 4'd0);
		push_req(OP_LOOKUP,  8'h01, 32'd7,  32'd350, 4'd0);

		for (int p = 0; p < 10; p++) begin
			write_entry_count(cfg_plan[p]);
			span = active_entries(cfg_plan[p]);
			if (p == 9) begin
				req_gap_pct   = 0;
				rsp_stall_pct = 0;
			end else begin
				req_gap_pct   = (p % 3 == 1) ? 0 : $urandom_range(5, 40);
				rsp_stall_pct = (p % 4 == 2) ? 0 : $urandom_range(5, 40);
			end
			count = 0;
			while (count < PHASE_ITEMS) begin
				r = random_request(span);
				req_pending.push_back(r);
				count++;
				// Half of the lookups are followed by the host filling the block.
				if (r.opcode == OP_LOOKUP && $urandom_range(0, 1) == 1) begin
					r.opcode       = OP_INSTALL;
					r.now          = r.now + $urandom_range(1, 20);
					r.install_slot = SLOT_W'($urandom_range(0, span - 1));
					req_pending.push_back(r);
					count++;
				end
				// Once, hold the sender until the directory has answered everything.
				if (p == 3 && !held && count >= PHASE_ITEMS / 2) begin
					held = 1'b1;
					wait_idle();
				end
			end
		end

		wait_idle();
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
sv/bcd_pkg.sv
sv/bcd_if.sv
sv/bcd_tag_ram.sv
sv/bcd_scan.sv
sv/block_cache_directory_oldest_replace_core.sv
sv/bcd_checker.sv
tb/tb_top.sv
